// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int NODE_W  = 6;
  localparam int COUNT_W = 7;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

  typedef logic [NODE_W-1:0] node_t;

endpackage

// ===== rtl/scc_edge_store.sv =====
// ----------------------------------------------------------------------------
// scc_edge_store
// Edge list memory with fill count; one append and one registered read a cycle.
// ----------------------------------------------------------------------------
module scc_edge_store #(
  parameter int MAX_EDGES = 256,
  parameter int CNT_W     = $clog2(MAX_EDGES + 1),
  parameter int AW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              wr_en,
  input  scc_pkg::node_t    wr_src,
  input  scc_pkg::node_t    wr_tgt,
  input  logic [CNT_W-1:0]  rd_addr,
  output scc_pkg::node_t    rd_src,
  output scc_pkg::node_t    rd_tgt,
  output logic [CNT_W-1:0]  count
);

  logic [2*scc_pkg::NODE_W-1:0] mem [MAX_EDGES];
  logic [CNT_W-1:0]             cnt_r;
  logic                         room;

  assign room  = cnt_r < CNT_W'(MAX_EDGES);
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (clr) begin
      cnt_r <= '0;
    end else if (wr_en && room) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      mem[cnt_r[AW-1:0]] <= {wr_tgt, wr_src};
    end
    {rd_tgt, rd_src} <= mem[rd_addr[AW-1:0]];
  end

endmodule

// ===== rtl/scc_walk_stack.sv =====
// ----------------------------------------------------------------------------
// scc_walk_stack
// Depth-first walk stack: saved node and edge cursor per level, registered read.
// ----------------------------------------------------------------------------
module scc_walk_stack #(
  parameter int MAX_NODES = 64,
  parameter int CNT_W     = 9,
  parameter int IW        = $clog2(MAX_NODES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_addr,
  input  scc_pkg::node_t    wr_node,
  input  logic [CNT_W-1:0]  wr_cur,
  input  logic [IW-1:0]     rd_addr,
  output scc_pkg::node_t    rd_node,
  output logic [CNT_W-1:0]  rd_cur
);

  logic [scc_pkg::NODE_W+CNT_W-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_cur, wr_node};
    end
    {rd_cur, rd_node} <= mem[rd_addr];
  end

endmodule

// ===== rtl/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components
// Stores a directed graph and lists its strongly connected components
// (forward depth-first finish order, then reverse-edge walks).
// ----------------------------------------------------------------------------
//  channel | ports                         | contents
//  in      | in_tvalid/tready/tdata[15:0]  | command, from_node, to_node
//  out     | out_tvalid/tready/tdata[15:0] | component, member_node
//          | out_tuser[0], out_tlast       | component_end, last of the run
//  cfg     | cfg_we, cfg_wdata[6:0]        | node_count
//
//  Clear and add are accepted while idle. A run reads and tests the edges
//  one at a time for each walk step, with extra states for each node push,
//  pop and finish: the edge memory read port is the loop that sets the time.
//  Reset is synchronous, active low; edge contents stay undefined until added.
//  Input is held off for the whole run; a stalled output holds the walk.
// ----------------------------------------------------------------------------
module strongly_connected_components #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] command, [7:2] from_node, [13:8] to_node
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] component, [11:6] member_node
  output logic [0:0]  out_tuser,  // [0] component_end
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_EDGES + 1);
  localparam int IW    = $clog2(MAX_NODES);
  localparam int CW    = scc_pkg::COUNT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FSTART = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_EVAL   = 4'd3;
  localparam logic [3:0] S_NOEDGE = 4'd4;
  localparam logic [3:0] S_POP    = 4'd5;
  localparam logic [3:0] S_RSTART = 4'd6;
  localparam logic [3:0] S_RLOAD  = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_FLUSH  = 4'd9;

  logic [3:0]           state_r;
  logic [CW-1:0]        node_count_r;
  logic [CW-1:0]        n_use;
  logic [CW-1:0]        s_r;
  scc_pkg::node_t       u_r;
  scc_pkg::node_t       v_r;
  logic [CNT_W-1:0]     e_r;
  logic [CW-1:0]        sp_r;
  logic [CW-1:0]        fin_cnt_r;
  logic [CW-1:0]        comp_r;
  logic                 rev_r;
  logic [MAX_NODES-1:0] fseen_r;
  logic [MAX_NODES-1:0] rseen_r;
  logic                 pend_valid_r;
  scc_pkg::node_t       pend_node_r;
  scc_pkg::node_t       pend_comp_r;
  logic                 pend_end_r;
  logic                 out_valid_r;
  logic [15:0]          out_data_r;
  logic                 out_end_r;
  logic                 out_last_r;

  logic [scc_pkg::CMD_W-1:0] cmd;
  scc_pkg::node_t       in_from;
  scc_pkg::node_t       in_to;
  logic                 in_fire;
  logic                 slot_free;
  logic                 out_load;

  scc_pkg::node_t       ed_src;
  scc_pkg::node_t       ed_tgt;
  logic [CNT_W-1:0]     edge_cnt;
  scc_pkg::node_t       stk_node;
  logic [CNT_W-1:0]     stk_cur;
  logic                 stk_we;
  logic [IW-1:0]        stk_waddr;
  logic [IW-1:0]        stk_raddr;

  logic [scc_pkg::NODE_W-1:0] fin_mem [MAX_NODES];
  scc_pkg::node_t       fin_rd;

  logic                 match;
  scc_pkg::node_t       nbr;

  assign cmd       = in_tdata[1:0];
  assign in_from   = in_tdata[7:2];
  assign in_to     = in_tdata[13:8];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign out_load  = pend_valid_r && slot_free && (state_r == S_EMIT || state_r == S_FLUSH);
  assign n_use     = (node_count_r > CW'(MAX_NODES)) ? CW'(MAX_NODES) : node_count_r;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_end_r;
  assign out_tlast    = out_last_r;

  // neighbor test on the edge just read
  always_comb begin
    if (rev_r) begin
      nbr   = ed_src;
      match = (ed_tgt == u_r) && ({1'b0, ed_src} < n_use) && !rseen_r[ed_src[IW-1:0]];
    end else begin
      nbr   = ed_tgt;
      match = (ed_src == u_r) && ({1'b0, ed_tgt} < n_use) && !fseen_r[ed_tgt[IW-1:0]];
    end
  end

  assign stk_we    = (state_r == S_EVAL) && match;
  assign stk_waddr = IW'(sp_r - 1'b1);
  assign stk_raddr = IW'(sp_r - 2'd2);

  scc_edge_store #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edges (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (in_fire && cmd == scc_pkg::CMD_CLEAR),
    .wr_en   (in_fire && cmd == scc_pkg::CMD_ADD
              && {1'b0, in_from} < n_use && {1'b0, in_to} < n_use),
    .wr_src  (in_from),
    .wr_tgt  (in_to),
    .rd_addr (e_r),
    .rd_src  (ed_src),
    .rd_tgt  (ed_tgt),
    .count   (edge_cnt)
  );

  scc_walk_stack #(
    .MAX_NODES (MAX_NODES),
    .CNT_W     (CNT_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_node (u_r),
    .wr_cur  (e_r + 1'b1),
    .rd_addr (stk_raddr),
    .rd_node (stk_node),
    .rd_cur  (stk_cur)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_NOEDGE && !rev_r) begin
      fin_mem[fin_cnt_r[IW-1:0]] <= u_r;
    end
    fin_rd <= fin_mem[IW'(fin_cnt_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CW'(64);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // load a new result when the slot frees, drop it once it transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      rev_r        <= 1'b0;
      fseen_r      <= '0;
      rseen_r      <= '0;
      fin_cnt_r    <= '0;
      comp_r       <= '0;
      sp_r         <= '0;
      s_r          <= '0;
      e_r          <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && cmd == scc_pkg::CMD_RUN) begin
            fseen_r   <= '0;
            rseen_r   <= '0;
            fin_cnt_r <= '0;
            comp_r    <= '0;
            s_r       <= '0;
            rev_r     <= 1'b0;
            state_r   <= S_FSTART;
          end
        end
        S_FSTART: begin
          if (s_r >= n_use) begin
            rev_r   <= 1'b1;
            state_r <= S_RSTART;
          end else if (fseen_r[s_r[IW-1:0]]) begin
            s_r <= s_r + 1'b1;
          end else begin
            fseen_r[s_r[IW-1:0]] <= 1'b1;
            u_r     <= s_r[scc_pkg::NODE_W-1:0];
            e_r     <= '0;
            sp_r    <= CW'(1);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // edge read is issued at e_r; result is checked next cycle
          state_r <= (e_r < edge_cnt) ? S_EVAL : S_NOEDGE;
        end
        S_EVAL: begin
          if (match) begin
            if (rev_r) begin
              rseen_r[nbr[IW-1:0]] <= 1'b1;
              v_r     <= nbr;
              state_r <= S_EMIT;
            end else begin
              fseen_r[nbr[IW-1:0]] <= 1'b1;
              state_r <= S_SCAN;
            end
            u_r  <= nbr;
            e_r  <= '0;
            sp_r <= sp_r + 1'b1;
          end else begin
            e_r     <= e_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_NOEDGE: begin
          sp_r <= sp_r - 1'b1;
          if (!rev_r) begin
            fin_cnt_r <= fin_cnt_r + 1'b1;
          end
          if (sp_r == CW'(1)) begin
            if (rev_r) begin
              pend_end_r <= 1'b1;
              comp_r     <= comp_r + 1'b1;
              state_r    <= S_RSTART;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_FSTART;
            end
          end else begin
            state_r <= S_POP;
          end
        end
        S_POP: begin
          u_r     <= stk_node;
          e_r     <= stk_cur;
          state_r <= S_SCAN;
        end
        S_RSTART: begin
          if (fin_cnt_r == '0) begin
            state_r <= S_FLUSH;
          end else begin
            fin_cnt_r <= fin_cnt_r - 1'b1;
            state_r   <= S_RLOAD;
          end
        end
        S_RLOAD: begin
          if (rseen_r[fin_rd[IW-1:0]]) begin
            state_r <= S_RSTART;
          end else begin
            rseen_r[fin_rd[IW-1:0]] <= 1'b1;
            u_r     <= fin_rd;
            v_r     <= fin_rd;
            e_r     <= '0;
            sp_r    <= CW'(1);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold the newest node back until its end flags are known
          if (!pend_valid_r || slot_free) begin
            if (pend_valid_r) begin
              out_data_r  <= {4'd0, pend_node_r, pend_comp_r};
              out_end_r   <= pend_end_r;
              out_last_r  <= 1'b0;
            end
            pend_valid_r <= 1'b1;
            pend_node_r  <= v_r;
            pend_comp_r  <= comp_r[scc_pkg::NODE_W-1:0];
            pend_end_r   <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_data_r   <= {4'd0, pend_node_r, pend_comp_r};
            out_end_r    <= pend_end_r;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/scc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scc_checker
// Watches the command, result and register ports of the component search
// block, predicts the component list of every run and compares each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module scc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam int NODES = 64;
  localparam int EDGES = 256;

  typedef struct {
    logic [5:0] comp;
    logic [5:0] node;
    logic       comp_end;
    logic       run_last;
  } member_t;

  member_t    members_q[$];
  logic [6:0] node_limit;
  logic [5:0] src_mem[EDGES];
  logic [5:0] dst_mem[EDGES];
  int         edge_total;

  task automatic report(input string what);
    $display("[%0t] %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int active_nodes();
    return (node_limit > NODES) ? NODES : int'(node_limit);
  endfunction

  // Kosaraju: forward finish order, then reverse-edge walks newest first.
  function automatic void predict_components();
    int      n;
    int      order[$];
    int      stk[NODES];
    int      cur[NODES];
    bit      fwd[NODES];
    bit      rev[NODES];
    int      sp, u, e, v, r, comp, produced;
    member_t m;
    n = active_nodes();
    fwd = '{default: 0};
    rev = '{default: 0};
    comp = 0;
    produced = 0;
    for (int s = 0; s < n; s++) begin
      if (fwd[s]) continue;
      fwd[s] = 1;
      stk[0] = s;
      cur[0] = 0;
      sp = 1;
      while (sp > 0) begin
        u = stk[sp-1];
        e = cur[sp-1];
        while (e < edge_total && !(src_mem[e] == u && dst_mem[e] < n && !fwd[dst_mem[e]]))
          e++;
        if (e < edge_total && sp < NODES) begin
          v = dst_mem[e];
          cur[sp-1] = e + 1;
          fwd[v] = 1;
          stk[sp] = v;
          cur[sp] = 0;
          sp++;
        end else begin
          sp--;
          if (order.size() < NODES) order = {order, u};
        end
      end
    end
    while (order.size() > 0) begin
      r = order.pop_back();
      if (r >= n || rev[r]) continue;
      rev[r] = 1;
      m = '{comp: comp[5:0], node: r[5:0], comp_end: 1'b0, run_last: 1'b0};
      members_q = {members_q, m};
      produced++;
      stk[0] = r;
      cur[0] = 0;
      sp = 1;
      while (sp > 0) begin
        u = stk[sp-1];
        e = cur[sp-1];
        while (e < edge_total && !(dst_mem[e] == u && src_mem[e] < n && !rev[src_mem[e]]))
          e++;
        if (e < edge_total && sp < NODES) begin
          v = src_mem[e];
          cur[sp-1] = e + 1;
          rev[v] = 1;
          m = '{comp: comp[5:0], node: v[5:0], comp_end: 1'b0, run_last: 1'b0};
          members_q = {members_q, m};
          produced++;
          stk[sp] = v;
          cur[sp] = 0;
          sp++;
        end else begin
          sp--;
        end
      end
      members_q[members_q.size()-1].comp_end = 1'b1;
      comp = (comp + 1) & 8'h7F;
    end
    if (produced > 0) members_q[members_q.size()-1].run_last = 1'b1;
  endfunction

  function automatic void apply_command(input logic [15:0] word);
    logic [1:0] cmd;
    int         f, t, n;
    cmd = word[1:0];
    f = word[7:2];
    t = word[13:8];
    n = active_nodes();
    if (cmd == scc_pkg::CMD_CLEAR) begin
      edge_total = 0;
    end else if (cmd == scc_pkg::CMD_ADD) begin
      if (f < n && t < n && edge_total < EDGES) begin
        src_mem[edge_total] = f[5:0];
        dst_mem[edge_total] = t[5:0];
        edge_total++;
      end
    end else if (cmd == scc_pkg::CMD_RUN) begin
      predict_components();
    end
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    member_t want;
    if (!rst_n) begin
      node_limit <= 7'd64;
      edge_total = 0;
      members_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (members_q.size() == 0) begin
          report($sformatf("unexpected result comp=%0d node=%0d",
                           out_tdata[5:0], out_tdata[11:6]));
        end else begin
          want = members_q.pop_front();
          if (out_tdata[5:0] !== want.comp)
            report($sformatf("component %0d, want %0d", out_tdata[5:0], want.comp));
          if (out_tdata[11:6] !== want.node)
            report($sformatf("member_node %0d, want %0d", out_tdata[11:6], want.node));
          if (out_tuser[0] !== want.comp_end)
            report($sformatf("component_end %b, want %b (node %0d)",
                             out_tuser[0], want.comp_end, want.node));
          if (out_tlast !== want.run_last)
            report($sformatf("tlast %b, want %b (node %0d)",
                             out_tlast, want.run_last, want.node));
        end
      end
      if (in_tvalid && in_tready) apply_command(in_tdata);
      if (cfg_we) node_limit <= cfg_wdata;
    end
    pending = members_q.size();
  end

endmodule

// ===== test/tb_strongly_connected_components.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strongly_connected_components
// Drives graph commands and node count writes into the component search
// block under several idle and stall mixes, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_strongly_connected_components;

  localparam int  CYCLE_LIMIT = 20000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_off = 1'b0;
  int          cycles = 0;
  int          node_span = 64;

  always #4 clk = ~clk;

  strongly_connected_components dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  scc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= !hold_off && ($urandom_range(99) >= recv_stall);

  task automatic send(input logic [1:0] cmd, input int f, input int t);
    if ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, t[5:0], f[5:0], cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_nodes(input int value);
    go_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[6:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    node_span = (value > 64) ? 64 : value;
  endtask

  // Mostly clear / load / run sequences, with stray edges and unused commands.
  task automatic random_phase(input int items);
    int left, k, lim;
    left = items;
    while (left > 0) begin
      case ($urandom_range(9))
        0: begin
          send(CMD_UNUSED, $urandom_range(63), $urandom_range(63));
          left--;
        end
        1: begin
          send(scc_pkg::CMD_ADD, $urandom_range(63), $urandom_range(63));
          left--;
        end
        default: begin
          if ($urandom_range(3) != 0) begin
            send(scc_pkg::CMD_CLEAR, $urandom_range(63), $urandom_range(63));
            left--;
          end
          k = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 20);
          if (k > left - 1) k = (left > 1) ? left - 1 : 0;
          lim = node_span - 1;
          repeat (k) begin
            if ($urandom_range(15) == 0)
              send(scc_pkg::CMD_ADD, $urandom_range(63), $urandom_range(63));
            else
              send(scc_pkg::CMD_ADD, $urandom_range(lim), $urandom_range(lim));
          end
          left -= k;
          send(scc_pkg::CMD_RUN, $urandom_range(63), $urandom_range(63));
          left--;
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty graph, cycles, self loop, corner nodes
    send(scc_pkg::CMD_RUN, 0, 0);
    send(scc_pkg::CMD_CLEAR, 63, 63);
    send(scc_pkg::CMD_ADD, 0, 1);
    send(scc_pkg::CMD_ADD, 1, 2);
    send(scc_pkg::CMD_ADD, 2, 0);
    send(scc_pkg::CMD_ADD, 2, 3);
    send(scc_pkg::CMD_ADD, 3, 3);
    send(scc_pkg::CMD_ADD, 63, 0);
    send(scc_pkg::CMD_ADD, 0, 63);
    send(scc_pkg::CMD_ADD, 5, 63);
    send(scc_pkg::CMD_ADD, 5, 63);
    send(CMD_UNUSED, 63, 63);
    send(scc_pkg::CMD_RUN, 63, 63);
    // lowered count skips stored edges and drops new out-of-range ones
    set_nodes(4);
    send(scc_pkg::CMD_ADD, 0, 5);
    send(scc_pkg::CMD_ADD, 1, 0);
    send(scc_pkg::CMD_RUN, 0, 0);
    set_nodes(0);
    send(scc_pkg::CMD_ADD, 0, 0);
    send(scc_pkg::CMD_RUN, 0, 0);
    set_nodes(1);
    send(scc_pkg::CMD_RUN, 0, 0);

    set_nodes(64);
    random_phase(50);
    set_nodes(13);
    send_idle = 52;
    random_phase(50);
    set_nodes(127);
    send_idle = 0;
    recv_stall = 52;
    fork
      random_phase(50);
      begin
        @(negedge clk);
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    set_nodes(40);
    send_idle = 33;
    recv_stall = 33;
    random_phase(50);

    go_quiet();
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
